>>> rtl/rsp_pkg.sv
// Shared constants and types for the ray-sphere nearest pick unit.
`timescale 1ns / 1ps
`default_nettype none
package rsp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shared multiply-accumulate unit widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 18;
  localparam int ACC_W   = 76;

  // Square root unit widths
  localparam int RAD_W  = 72;
  localparam int ROOT_W = RAD_W / 2;

  // Divider widths: quotient magnitude never exceeds 2^FRAC_BITS
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int DVS_W  = 32;
  localparam int DVD_W  = DVS_W + FRAC_BITS;

  localparam logic [30:0] RADIUS_FLOOR   = 31'((64'd1 << FRAC_BITS) / 1000);
  localparam logic [30:0] RADIUS_DEFAULT = 31'(((64'd6 << FRAC_BITS) + 64'd5) / 10);
  localparam logic [30:0] RADIUS_RESET   = 31'd39322;
  localparam logic [31:0] DIR_Z_RESET    = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIR_X       = 3'd3,
    REG_DIR_Y       = 3'd4,
    REG_DIR_Z       = 3'd5,
    REG_PICK_RADIUS = 3'd6,
    REG_PICK_ENABLE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic en;   // update the accumulator
    logic clr;  // start from zero
    logic neg;  // subtract the product
    logic sh;   // product weighted by 2^MUL_B_W
  } mac_ctl_t;

endpackage
`default_nettype wire

>>> rtl/rsp_if.sv
// Entity and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface rsp_ent_if;
  logic               valid;
  logic               ready;
  logic               entity_valid;
  logic [31:0]        entity_id;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic               last_entity;

  modport source (output valid, entity_valid, entity_id, center_x, center_y, center_z,
                  last_entity, input ready);
  modport sink (input valid, entity_valid, entity_id, center_x, center_y, center_z,
                last_entity, output ready);
endinterface

interface rsp_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [31:0]        hit_id;
  logic [30:0]        hit_distance;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;

  modport source (output valid, hit, hit_id, hit_distance, hit_x, hit_y, hit_z,
                  input ready);
  modport sink (input valid, hit, hit_id, hit_distance, hit_x, hit_y, hit_z,
                output ready);
endinterface
`default_nettype wire

>>> rtl/rsp_mac.sv
// Shared multiply-accumulate unit: acc = acc +/- (a * b) << {0 | 18}.
`timescale 1ns / 1ps
`default_nettype none
module rsp_mac (
  input  wire                                    clk_i,
  input  wire rsp_pkg::mac_ctl_t                 ctl_i,
  input  wire [rsp_pkg::MUL_A_W-1:0]             a_i,
  input  wire [rsp_pkg::MUL_B_W-1:0]             b_i,
  output logic signed [rsp_pkg::ACC_W-1:0]       acc_o
);

  localparam int PW = rsp_pkg::MUL_A_W + rsp_pkg::MUL_B_W;

  logic [PW-1:0]                          prod;
  logic [rsp_pkg::ACC_W-1:0]              term;
  logic signed [rsp_pkg::ACC_W-1:0]       base, acc_d, acc_q;

  always_comb begin
    prod  = a_i * b_i;
    term  = ctl_i.sh ? (rsp_pkg::ACC_W'(prod) << rsp_pkg::MUL_B_W) : rsp_pkg::ACC_W'(prod);
    base  = ctl_i.clr ? '0 : acc_q;
    acc_d = ctl_i.neg ? base - $signed(term) : base + $signed(term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

>>> rtl/rsp_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsp_sqrt (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [rsp_pkg::RAD_W-1:0]     rad_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [rsp_pkg::ROOT_W-1:0]   root_o
);

  localparam int RW  = rsp_pkg::ROOT_W + 2;
  localparam int CW  = $clog2(rsp_pkg::ROOT_W);

  logic [rsp_pkg::RAD_W-1:0]  rad_q;
  logic [RW-1:0]              rem_q;
  logic [rsp_pkg::ROOT_W-1:0] root_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;
  logic [RW+1:0]              rem_sh, trial;
  logic                       ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[rsp_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(rsp_pkg::ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= RW'(ge ? rem_sh - trial : rem_sh);
      root_q <= {root_q[rsp_pkg::ROOT_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> rtl/rsp_div.sv
// Restoring divider for direction normalization, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsp_div (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [rsp_pkg::DVD_W-1:0]    dividend_i,
  input  wire [rsp_pkg::DVS_W-1:0]    divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [rsp_pkg::QUO_W-1:0]   quot_o
);

  localparam int CW = $clog2(rsp_pkg::QUO_W);
  localparam int SW = rsp_pkg::DVD_W + 1;

  logic [rsp_pkg::DVD_W-1:0] rem_q;
  logic [SW-1:0]             dvs_q;
  logic [rsp_pkg::QUO_W-1:0] quo_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;
  logic                      ge;

  assign ge = {1'b0, rem_q} >= dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(rsp_pkg::QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dvs_q <= SW'(divisor_i) << (rsp_pkg::QUO_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - rsp_pkg::DVD_W'(dvs_q);
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[rsp_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> rtl/ray_sphere_nearest_pick_unit.sv
// Top level: configuration, pick sequencer and result register.
//
//  channel  | dir | members
//  ---------+-----+-------------------------------------------------------------
//  ent_i    | in  | valid/ready, entity_valid, entity_id, center_x/y/z, last_entity
//  res_o    | out | valid/ready, hit, hit_id, hit_distance, hit_x/y/z
//  cfg_*_i  | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// First beat of a run: normalizes the direction (6 MAC steps, root launch and wait on
// the root, then three divides when the direction is nonzero).
// Valid entity: 13 passes through the shared multiply-accumulate unit, then a wait on the shared
// square root unless the discriminant is negative. Skipped entity: no arithmetic.
// Last beat adds an emit step, preceded with a hit by the hit point, one axis at a time.
// Reset leaves the unit idle.
// ent_i.ready is high only while idle; a pending result stalls only at the next emit.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_nearest_pick_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [rsp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [rsp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  rsp_ent_if.sink                             ent_i,
  rsp_res_if.source                           res_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DSQ, ST_LSQ, ST_LWAIT, ST_DIVGO, ST_DIVW, ST_ENT, ST_H, ST_HFIN,
    ST_DISC, ST_DFIN, ST_SWAIT, ST_TSEL, ST_NEXT, ST_HP, ST_HPFIN, ST_EMIT
  } state_e;

  localparam int F = rsp_pkg::FRAC_BITS;
  localparam int A = rsp_pkg::MUL_A_W;
  localparam int B = rsp_pkg::MUL_B_W;
  localparam int U = rsp_pkg::QUO_W;

  // configuration
  logic signed [31:0] origin_q [3];
  logic signed [31:0] dir_q    [3];
  logic [30:0]        radius_q;
  logic               enable_q;

  // held entity
  logic               it_valid_q, it_last_q;
  logic [31:0]        it_id_q;
  logic signed [31:0] center_q [3];

  // run state
  logic signed [U:0]  unit_q [3];
  logic               dir_ok_q, run_started_q, found_q;
  logic [31:0]        best_dist_q, best_id_q, len_q;
  logic signed [32:0] oc_q [3];
  logic [34:0]        h_mag_q;
  logic               h_neg_q;
  logic signed [31:0] hp_q [3];
  logic [3:0]         step_q;
  state_e             state_q;

  // result register
  logic               out_valid_q, out_hit_q;
  logic [31:0]        out_id_q;
  logic [30:0]        out_dist_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;

  // shared units
  rsp_pkg::mac_ctl_t                 mac_ctl;
  logic [A-1:0]                      mac_a;
  logic [B-1:0]                      mac_b;
  logic signed [rsp_pkg::ACC_W-1:0]  acc;
  logic [rsp_pkg::ACC_W-1:0]         acc_mag;
  logic                              sq_start, sq_busy, sq_done;
  logic [rsp_pkg::RAD_W-1:0]         sq_rad;
  logic [rsp_pkg::ROOT_W-1:0]        sq_root;
  logic                              dv_start, dv_busy, dv_done;
  logic [U-1:0]                      dv_quot;

  logic [30:0]        r_eff;
  logic [1:0]         ax, dax;
  logic signed [37:0] nh, sv, t0, t1, tsel;
  logic               t_ok;
  logic [31:0]        tclamp;
  logic [31:0]        hq_mag;
  logic signed [33:0] psum;
  logic signed [31:0] psat;
  logic               emit_go, hit_now;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [U-1:0] umag(input logic signed [U:0] v);
    return v[U] ? U'(-v) : U'(v);
  endfunction

  rsp_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  rsp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  rsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i ({mag32(dir_q[ax]), F'(0)}),
    .divisor_i  (len_q),
    .busy_o     (dv_busy),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  always_comb begin
    r_eff   = (radius_q <= rsp_pkg::RADIUS_FLOOR) ? rsp_pkg::RADIUS_DEFAULT : radius_q;
    ax      = step_q[1:0];
    acc_mag = acc[rsp_pkg::ACC_W-1] ? rsp_pkg::ACC_W'(-acc) : rsp_pkg::ACC_W'(acc);

    if (step_q[3:1] == 3'd2) begin
      dax = 2'd0;
    end else if (step_q[3:1] == 3'd3) begin
      dax = 2'd1;
    end else begin
      dax = 2'd2;
    end

    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      ST_DSQ: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (step_q == 4'd0);
        mac_ctl.sh  = step_q[0];
        mac_a       = A'(mag32(dir_q[step_q[2:1]]));
        mac_b       = step_q[0] ? B'(mag32(dir_q[step_q[2:1]]) >> B)
                                : B'(mag32(dir_q[step_q[2:1]]));
      end
      ST_H: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (step_q == 4'd0);
        mac_ctl.neg = oc_q[ax][32] ^ unit_q[ax][U];
        mac_a       = A'(mag33(oc_q[ax]));
        mac_b       = B'(umag(unit_q[ax]));
      end
      ST_DISC: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (step_q == 4'd0);
        mac_ctl.sh  = step_q[0];
        if (step_q < 4'd2) begin
          mac_a = A'(h_mag_q);
          mac_b = step_q[0] ? B'(h_mag_q >> B) : h_mag_q[B-1:0];
        end else if (step_q < 4'd4) begin
          mac_a = A'(r_eff);
          mac_b = step_q[0] ? B'(r_eff >> B) : r_eff[B-1:0];
        end else begin
          mac_ctl.neg = 1'b1;
          mac_a       = A'(mag33(oc_q[dax]));
          mac_b       = step_q[0] ? B'(mag33(oc_q[dax]) >> B) : B'(mag33(oc_q[dax]));
        end
      end
      ST_HP: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_ctl.neg = unit_q[ax][U];
        mac_a       = A'(best_dist_q[30:0]);
        mac_b       = B'(umag(unit_q[ax]));
      end
      default: begin
        mac_ctl = '0;
      end
    endcase

    sq_start = 1'b0;
    sq_rad   = rsp_pkg::RAD_W'(acc_mag);
    if (state_q == ST_LSQ) begin
      sq_start = 1'b1;
    end else if (state_q == ST_DFIN && !acc[rsp_pkg::ACC_W-1]) begin
      sq_start = 1'b1;
    end
    dv_start = (state_q == ST_DIVGO);

    // nearer non-negative root, clamped to 31 bits
    nh     = h_neg_q ? $signed({3'b000, h_mag_q}) : -$signed({3'b000, h_mag_q});
    sv     = $signed({2'b00, sq_root});
    t0     = nh - sv;
    t1     = nh + sv;
    t_ok   = !t0[37] || !t1[37];
    tsel   = !t0[37] ? t0 : t1;
    tclamp = (tsel > 38'sd2147483647) ? 32'h7FFF_FFFF : 32'(tsel);

    // hit point: origin + trunc(unit * t / 2^F), saturated
    hq_mag = 32'(acc_mag >> F);
    psum   = 34'(origin_q[ax]) + (acc[rsp_pkg::ACC_W-1] ? -$signed({2'b00, hq_mag})
                                                       : $signed({2'b00, hq_mag}));
    if (psum > 34'sd2147483647) begin
      psat = 32'sh7FFF_FFFF;
    end else if (psum < -34'sd2147483648) begin
      psat = 32'sh8000_0000;
    end else begin
      psat = 32'(psum);
    end

    emit_go = (state_q == ST_EMIT) && (!out_valid_q || res_o.ready);
    hit_now = found_q && dir_ok_q && enable_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= $signed(rsp_pkg::DIR_Z_RESET);
      radius_q    <= rsp_pkg::RADIUS_RESET;
      enable_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (rsp_pkg::reg_idx_e'(cfg_idx_i))
        rsp_pkg::REG_ORIGIN_X:    origin_q[0] <= $signed(cfg_data_i);
        rsp_pkg::REG_ORIGIN_Y:    origin_q[1] <= $signed(cfg_data_i);
        rsp_pkg::REG_ORIGIN_Z:    origin_q[2] <= $signed(cfg_data_i);
        rsp_pkg::REG_DIR_X:       dir_q[0]    <= $signed(cfg_data_i);
        rsp_pkg::REG_DIR_Y:       dir_q[1]    <= $signed(cfg_data_i);
        rsp_pkg::REG_DIR_Z:       dir_q[2]    <= $signed(cfg_data_i);
        rsp_pkg::REG_PICK_RADIUS: radius_q    <= cfg_data_i[30:0];
        rsp_pkg::REG_PICK_ENABLE: enable_q    <= cfg_data_i[0];
        default:                  enable_q    <= enable_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && ent_i.valid) begin
      it_valid_q  <= ent_i.entity_valid;
      it_last_q   <= ent_i.last_entity;
      it_id_q     <= ent_i.entity_id;
      center_q[0] <= ent_i.center_x;
      center_q[1] <= ent_i.center_y;
      center_q[2] <= ent_i.center_z;
    end
    if (state_q == ST_LWAIT && sq_done) begin
      len_q <= sq_root[31:0];
    end
    if (state_q == ST_ENT) begin
      oc_q[0] <= 33'(origin_q[0]) - 33'(center_q[0]);
      oc_q[1] <= 33'(origin_q[1]) - 33'(center_q[1]);
      oc_q[2] <= 33'(origin_q[2]) - 33'(center_q[2]);
    end
    if (state_q == ST_HFIN) begin
      h_mag_q <= 35'(acc_mag >> F);
      h_neg_q <= acc[rsp_pkg::ACC_W-1];
    end
    if (state_q == ST_HPFIN) begin
      hp_q[ax] <= psat;
    end
    if (emit_go) begin
      out_hit_q  <= hit_now;
      out_id_q   <= hit_now ? best_id_q : '0;
      out_dist_q <= hit_now ? best_dist_q[30:0] : '0;
      out_x_q    <= hit_now ? hp_q[0] : '0;
      out_y_q    <= hit_now ? hp_q[1] : '0;
      out_z_q    <= hit_now ? hp_q[2] : '0;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      unit_q[0]     <= '0;
      unit_q[1]     <= '0;
      unit_q[2]     <= '0;
      dir_ok_q      <= 1'b0;
      run_started_q <= 1'b0;
      found_q       <= 1'b0;
      best_dist_q   <= '1;
      best_id_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (ent_i.valid) begin
            state_q <= run_started_q ? ST_ENT : ST_DSQ;
          end
        end
        ST_DSQ: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd5) begin
            state_q <= ST_LSQ;
          end
        end
        ST_LSQ: begin
          dir_ok_q <= (acc != '0);
          state_q  <= ST_LWAIT;
        end
        ST_LWAIT: begin
          step_q <= '0;
          if (sq_done) begin
            if (dir_ok_q) begin
              state_q <= ST_DIVGO;
            end else begin
              run_started_q <= 1'b1;
              state_q       <= ST_ENT;
            end
          end
        end
        ST_DIVGO: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (dv_done) begin
            unit_q[ax] <= dir_q[ax][31] ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
            step_q     <= step_q + 1'b1;
            if (step_q == 4'd2) begin
              run_started_q <= 1'b1;
              state_q       <= ST_ENT;
            end else begin
              state_q <= ST_DIVGO;
            end
          end
        end
        ST_ENT: begin
          step_q  <= '0;
          state_q <= (it_valid_q && dir_ok_q) ? ST_H : ST_NEXT;
        end
        ST_H: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd2) begin
            state_q <= ST_HFIN;
          end
        end
        ST_HFIN: begin
          step_q  <= '0;
          state_q <= ST_DISC;
        end
        ST_DISC: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd9) begin
            state_q <= ST_DFIN;
          end
        end
        ST_DFIN: begin
          // negative discriminant: miss
          state_q <= acc[rsp_pkg::ACC_W-1] ? ST_NEXT : ST_SWAIT;
        end
        ST_SWAIT: begin
          if (sq_done) begin
            state_q <= ST_TSEL;
          end
        end
        ST_TSEL: begin
          if (t_ok && tclamp < best_dist_q) begin
            best_dist_q <= tclamp;
            best_id_q   <= it_id_q;
            found_q     <= 1'b1;
          end
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          step_q <= '0;
          if (!it_last_q) begin
            state_q <= ST_IDLE;
          end else if (hit_now) begin
            state_q <= ST_HP;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_HP: begin
          state_q <= ST_HPFIN;
        end
        ST_HPFIN: begin
          step_q  <= step_q + 1'b1;
          state_q <= (step_q == 4'd2) ? ST_EMIT : ST_HP;
        end
        ST_EMIT: begin
          if (emit_go) begin
            run_started_q <= 1'b0;
            dir_ok_q      <= 1'b0;
            found_q       <= 1'b0;
            best_dist_q   <= '1;
            best_id_q     <= '0;
            unit_q[0]     <= '0;
            unit_q[1]     <= '0;
            unit_q[2]     <= '0;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign ent_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.hit          = out_hit_q;
  assign res_o.hit_id       = out_id_q;
  assign res_o.hit_distance = out_dist_q;
  assign res_o.hit_x        = out_x_q;
  assign res_o.hit_y        = out_y_q;
  assign res_o.hit_z        = out_z_q;

  // a stored hit distance is always clamped to 31 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> !best_dist_q[31])
    else $error("best distance above 31 bits with a hit recorded");

  // an idle unit between runs carries no run state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !run_started_q) |-> (!dir_ok_q && !found_q))
    else $error("run state left over after a run closed");

  // a no-hit result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.hit) |-> (res_o.hit_id == '0 && res_o.hit_distance == '0 &&
                                     res_o.hit_x == '0 && res_o.hit_y == '0 &&
                                     res_o.hit_z == '0))
    else $error("no-hit result with nonzero fields");

  // shared units are quiet whenever a new beat can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_i.ready |-> (!sq_busy && !dv_busy))
    else $error("entity taken while an iterative unit is busy");

endmodule
`default_nettype wire
